// ===== rtl/ray_edge_pick_nearest_core_assert.svh =====
// Assertion macros for the ray edge picking block.
// Included by the core RTL file, which carries the concurrent checks; no other dependencies.
`ifndef RAY_EDGE_PICK_NEAREST_CORE_ASSERT_SVH
`define RAY_EDGE_PICK_NEAREST_CORE_ASSERT_SVH
`ifndef SYNTHESIS
`define REP_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
else $error("rep assertion failed");
`define REP_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
else $error("rep assertion failed");
`else
`define REP_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define REP_ASSERT_NXT(lbl, clk, rstn, ante, cons)
`endif
`endif

// ===== rtl/rep_pkg.sv =====
// Shared widths, constants and types of the ray edge picking block.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package rep_pkg;
	localparam int COORD_W   = 32;
	localparam int DIST_W    = 31;
	localparam int IDX_W     = 16;
	localparam int MAX_EDGES = 65536;
	localparam int CNT_W     = $clog2(MAX_EDGES) + 1;
	localparam int MUL_A_W   = 36;
	localparam int MUL_B_W   = 33;
	localparam int MUL_P_W   = MUL_A_W + MUL_B_W;
	localparam int DIV_W     = 62;
	localparam int Q_W       = 31;
	localparam int FRAC_BITS = 30;
	localparam int SQ_W      = 64;
	localparam int ROOT_W    = 32;
	localparam logic [Q_W-1:0]    ONE_Q30  = Q_W'(1) << FRAC_BITS;
	localparam logic [DIST_W-1:0] DIST_MAX = '1;
	localparam logic [DIST_W-1:0] THR_RST  = DIST_W'(6554);

	// register index on the config port, byte address = 4 * index
	typedef enum logic [2:0] {
		REG_ORG_X = 3'd0,
		REG_ORG_Y = 3'd1,
		REG_ORG_Z = 3'd2,
		REG_DIR_X = 3'd3,
		REG_DIR_Y = 3'd4,
		REG_DIR_Z = 3'd5,
		REG_THR   = 3'd6
	} reg_idx_t;

	typedef struct packed {
		logic busy;
		logic done;
	} unit_stat_t;
endpackage
`default_nettype wire

// ===== rtl/rep_edge_if.sv =====
// Edge input channel: valid/ready plus the two endpoints and the last mark.
// Depends on rep_pkg.
`timescale 1ns / 1ps
`default_nettype none
interface rep_edge_if;
	import rep_pkg::*;
	logic                      valid;
	logic                      ready;
	logic signed [COORD_W-1:0] start_x;
	logic signed [COORD_W-1:0] start_y;
	logic signed [COORD_W-1:0] start_z;
	logic signed [COORD_W-1:0] end_x;
	logic signed [COORD_W-1:0] end_y;
	logic signed [COORD_W-1:0] end_z;
	logic                      last_edge;
	modport source (output valid, start_x, start_y, start_z, end_x, end_y, end_z, last_edge,
		input ready);
	modport sink (input valid, start_x, start_y, start_z, end_x, end_y, end_z, last_edge,
		output ready);
endinterface
`default_nettype wire

// ===== rtl/rep_result_if.sv =====
// Pick result channel: valid/ready plus hit, edge index and distance.
// Depends on rep_pkg.
`timescale 1ns / 1ps
`default_nettype none
interface rep_result_if;
	import rep_pkg::*;
	logic              valid;
	logic              ready;
	logic              hit;
	logic [IDX_W-1:0]  hit_edge_index;
	logic [DIST_W-1:0] hit_distance;
	modport source (output valid, hit, hit_edge_index, hit_distance, input ready);
	modport sink (input valid, hit, hit_edge_index, hit_distance, output ready);
endinterface
`default_nettype wire

// ===== rtl/ray_edge_pick_nearest_core.sv =====
// Top level of the ray edge picking block: config port, sequencer, state.
// Depends on rep_pkg, rep_edge_if, rep_result_if, rep_mul, rep_div, rep_sqrt.
`timescale 1ns / 1ps
`default_nettype none
`include "ray_edge_pick_nearest_core_assert.svh"
//
//  channel  | dir | handshake        | payload
//  ---------+-----+------------------+-----------------------------------------
//  edges    | in  | valid/ready      | start_x/y/z, end_x/y/z, last_edge
//  pick     | out | valid/ready      | hit, hit_edge_index, hit_distance
//  apb      | in  | psel/penable     | paddr[4:2] = register, pwdata/prdata
//
//  One edge at a time. A normal edge runs 24 multiplies on the shared
//  multiplier, a 30-step divide and a 32-step square root. The first edge of
//  a pass also normalizes the ray direction (up to 30 shift steps, 3
//  multiplies, one root, 3 divides). The pick register frees the input side:
//  a new edge is taken while the last result waits; only a second last-edge
//  result stalls until pick is taken.
//  Reset: async active low, ray points down -z, threshold about 0.1.
//
module ray_edge_pick_nearest_core (
	input  wire logic        clk,
	input  wire logic        arst_n,
	rep_edge_if.sink         edges,
	rep_result_if.source     pick,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [4:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready
);
	import rep_pkg::*;

	localparam int ACC_W = 68;
	localparam int X_W   = 35;
	localparam int AB_W  = 30;
	localparam int P_W   = 34;

	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_DNORM = 4'd1;
	localparam logic [3:0] S_CHK   = 4'd2;
	localparam logic [3:0] S_MUL   = 4'd3;
	localparam logic [3:0] S_MWB   = 4'd4;
	localparam logic [3:0] S_KSH   = 4'd5;
	localparam logic [3:0] S_SQRT  = 4'd6;
	localparam logic [3:0] S_DIV   = 4'd7;
	localparam logic [3:0] S_FIN   = 4'd8;

	// multiplier micro-ops
	localparam logic [2:0] OP_DSQ  = 3'd0;  // direction magnitude squared
	localparam logic [2:0] OP_PDOT = 3'd1;  // v . u
	localparam logic [2:0] OP_PROJ = 3'd2;  // v - p*u
	localparam logic [2:0] OP_DEN  = 3'd3;  // B . B
	localparam logic [2:0] OP_DAB  = 3'd4;  // A . B
	localparam logic [2:0] OP_TB   = 3'd5;  // A + t*B
	localparam logic [2:0] OP_PSQ  = 3'd6;  // closest vector squared

	// ---- configuration registers ----
	logic signed [31:0] cfg_org_q [3];
	logic signed [31:0] cfg_dir_q [3];
	logic [DIST_W-1:0]  cfg_thr_q;
	logic               cfg_wr;
	logic [2:0]         cfg_idx;

	assign pready  = 1'b1;
	assign cfg_idx = paddr[4:2];
	assign cfg_wr  = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_org_q[0] <= '0;
			cfg_org_q[1] <= '0;
			cfg_org_q[2] <= '0;
			cfg_dir_q[0] <= '0;
			cfg_dir_q[1] <= '0;
			cfg_dir_q[2] <= -32'sd65536;
			cfg_thr_q    <= THR_RST;
		end else if (cfg_wr) begin
			case (cfg_idx)
				REG_ORG_X: cfg_org_q[0] <= pwdata;
				REG_ORG_Y: cfg_org_q[1] <= pwdata;
				REG_ORG_Z: cfg_org_q[2] <= pwdata;
				REG_DIR_X: cfg_dir_q[0] <= pwdata;
				REG_DIR_Y: cfg_dir_q[1] <= pwdata;
				REG_DIR_Z: cfg_dir_q[2] <= pwdata;
				REG_THR:   cfg_thr_q    <= pwdata[DIST_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (cfg_idx)
			REG_ORG_X: prdata = cfg_org_q[0];
			REG_ORG_Y: prdata = cfg_org_q[1];
			REG_ORG_Z: prdata = cfg_org_q[2];
			REG_DIR_X: prdata = cfg_dir_q[0];
			REG_DIR_Y: prdata = cfg_dir_q[1];
			REG_DIR_Z: prdata = cfg_dir_q[2];
			REG_THR:   prdata = {1'b0, cfg_thr_q};
			default:   prdata = '0;
		endcase
	end

	// ---- sequencer and datapath state ----
	logic [3:0]               state_q;
	logic [2:0]               op_q;
	logic [1:0]               idx_q;
	logic                     side_q;   // 0: edge vector E, 1: offset W
	logic                     dphase_q; // direction normalize in progress
	logic                     last_q;
	logic [CNT_W-1:0]         cnt_q;
	logic [DIST_W-1:0]        best_dist_q;
	logic [IDX_W-1:0]         best_idx_q;
	logic                     found_q;
	logic                     out_valid_q;
	logic                     out_hit_q;
	logic [IDX_W-1:0]         out_idx_q;
	logic [DIST_W-1:0]        out_dist_q;

	logic [31:0]              m_q [3];
	logic [31:0]              mx_q;
	logic signed [31:0]       u_q [3];
	logic signed [31:0]       v_q [2][3];
	logic signed [X_W-1:0]    x_q [2][3];
	logic signed [AB_W-1:0]   a_q [3];
	logic signed [AB_W-1:0]   b_q [3];
	logic signed [P_W-1:0]    p_q;
	logic signed [ACC_W-1:0]  acc_q;
	logic [DIV_W-1:0]         den_q;
	logic [Q_W-1:0]           t_q;
	logic [30:0]              pm_q [3];
	logic [ROOT_W-1:0]        len_q;
	logic [2:0]               k_q;

	function automatic logic signed [31:0] sat32(input logic signed [32:0] d);
		if (d > 33'sh0_7FFF_FFFF) begin
			return 32'sh7FFF_FFFF;
		end else if (d < -33'sh0_8000_0000) begin
			return 32'sh8000_0000;
		end
		return d[31:0];
	endfunction

	function automatic logic [31:0] mag32(input logic signed [31:0] d);
		return d[31] ? 32'(-d) : 32'(d);
	endfunction

	function automatic logic [X_W-1:0] magx(input logic signed [X_W-1:0] d);
		return d[X_W-1] ? X_W'(-d) : X_W'(d);
	endfunction

	// ---- input side ----
	logic                      in_ready;
	logic                      in_fire;
	logic signed [COORD_W-1:0] e_in [3];
	logic signed [COORD_W-1:0] s_in [3];
	logic [31:0]               dmag [3];
	logic [31:0]               dmax;

	assign in_ready    = state_q == S_IDLE;
	assign in_fire     = edges.valid && in_ready;
	assign edges.ready = in_ready;
	assign s_in[0] = edges.start_x;
	assign s_in[1] = edges.start_y;
	assign s_in[2] = edges.start_z;
	assign e_in[0] = edges.end_x;
	assign e_in[1] = edges.end_y;
	assign e_in[2] = edges.end_z;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			dmag[i] = mag32(cfg_dir_q[i]);
		end
		dmax = dmag[0];
		if (dmag[1] > dmax) dmax = dmag[1];
		if (dmag[2] > dmax) dmax = dmag[2];
	end

	// ---- shared multiplier operand select ----
	logic signed [MUL_A_W-1:0] mul_a;
	logic signed [MUL_B_W-1:0] mul_b;
	logic signed [MUL_P_W-1:0] mul_p;

	always_comb begin
		case (op_q)
			OP_DSQ: begin
				mul_a = $signed({4'd0, m_q[idx_q]});
				mul_b = $signed({1'b0, m_q[idx_q]});
			end
			OP_PDOT: begin
				mul_a = MUL_A_W'(v_q[side_q][idx_q]);
				mul_b = MUL_B_W'(u_q[idx_q]);
			end
			OP_PROJ: begin
				mul_a = MUL_A_W'(p_q);
				mul_b = MUL_B_W'(u_q[idx_q]);
			end
			OP_DEN: begin
				mul_a = MUL_A_W'(b_q[idx_q]);
				mul_b = MUL_B_W'(b_q[idx_q]);
			end
			OP_DAB: begin
				mul_a = MUL_A_W'(a_q[idx_q]);
				mul_b = MUL_B_W'(b_q[idx_q]);
			end
			OP_TB: begin
				mul_a = $signed({5'd0, t_q});
				mul_b = MUL_B_W'(b_q[idx_q]);
			end
			OP_PSQ: begin
				mul_a = $signed({5'd0, pm_q[idx_q]});
				mul_b = $signed({2'd0, pm_q[idx_q]});
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	rep_mul u_mul (
		.clk (clk),
		.en  (state_q == S_MUL),
		.a   (mul_a),
		.b   (mul_b),
		.p   (mul_p)
	);

	// ---- write-back arithmetic ----
	logic signed [ACC_W-1:0]   sum_w;
	logic signed [ACC_W-1:0]   num_w;
	logic                      num_pos;
	logic signed [MUL_P_W-1:0] prod_sh;
	logic signed [X_W-1:0]     proj_w;
	logic signed [31:0]        c_w;
	logic [31:0]               cmag_w;

	assign sum_w   = acc_q + ACC_W'(mul_p);
	assign num_w   = -sum_w;
	assign num_pos = !num_w[ACC_W-1] && (num_w != '0);
	assign prod_sh = mul_p >>> FRAC_BITS;
	assign proj_w  = X_W'(v_q[side_q][idx_q]) - X_W'(prod_sh);
	assign c_w     = 32'(a_q[idx_q]) + 32'(prod_sh);
	assign cmag_w  = mag32(c_w);

	// ---- block shift: k from the top set bit of all across-parts ----
	logic [X_W-1:0] or_mag;
	logic [2:0]     k_w;

	always_comb begin
		or_mag = '0;
		for (int s = 0; s < 2; s++) begin
			for (int i = 0; i < 3; i++) begin
				or_mag = or_mag | magx(x_q[s][i]);
			end
		end
		if (or_mag[34])      k_w = 3'd6;
		else if (or_mag[33]) k_w = 3'd5;
		else if (or_mag[32]) k_w = 3'd4;
		else if (or_mag[31]) k_w = 3'd3;
		else if (or_mag[30]) k_w = 3'd2;
		else if (or_mag[29]) k_w = 3'd1;
		else                 k_w = 3'd0;
	end

	// ---- square root and divider ----
	logic              sq_start;
	logic [ROOT_W-1:0] sq_root;
	unit_stat_t        sq_stat;
	logic              div_start;
	logic [DIV_W-1:0]  div_num;
	logic [DIV_W-1:0]  div_den;
	logic [Q_W-1:0]    div_quo;
	unit_stat_t        div_stat;

	assign sq_start = (state_q == S_MWB) && (idx_q == 2'd2) &&
		(op_q == OP_DSQ || op_q == OP_PSQ);

	rep_sqrt u_sqrt (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (sq_start),
		.x      (sum_w[SQ_W-1:0]),
		.root   (sq_root),
		.stat   (sq_stat)
	);

	always_comb begin
		div_start = 1'b0;
		div_num   = num_w[DIV_W-1:0];
		div_den   = den_q;
		if (state_q == S_MWB && op_q == OP_DAB && idx_q == 2'd2 && den_q != '0 && num_pos) begin
			div_start = 1'b1;
		end else if (state_q == S_SQRT && dphase_q && sq_stat.done) begin
			div_start = 1'b1;
			div_num   = DIV_W'(m_q[0]);
			div_den   = DIV_W'(sq_root);
		end else if (state_q == S_DIV && dphase_q && div_stat.done && idx_q != 2'd2) begin
			div_start = 1'b1;
			div_num   = DIV_W'(m_q[idx_q + 2'd1]);
			div_den   = DIV_W'(len_q);
		end
	end

	rep_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (div_den),
		.quo    (div_quo),
		.stat   (div_stat)
	);

	// distance = root << k, saturated
	logic [ROOT_W+6:0]  dist_full;
	logic [DIST_W-1:0]  dist_w;
	logic               u_zero;
	logic               out_busy;

	assign dist_full = (ROOT_W + 7)'(sq_root) << k_q;
	assign dist_w    = (|dist_full[ROOT_W+6:DIST_W]) ? DIST_MAX : dist_full[DIST_W-1:0];
	assign u_zero    = (u_q[0] == '0) && (u_q[1] == '0) && (u_q[2] == '0);
	assign out_busy  = out_valid_q && !pick.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			op_q        <= OP_DSQ;
			idx_q       <= '0;
			side_q      <= 1'b0;
			dphase_q    <= 1'b0;
			last_q      <= 1'b0;
			cnt_q       <= '0;
			best_dist_q <= THR_RST;
			best_idx_q  <= '0;
			found_q     <= 1'b0;
			out_valid_q <= 1'b0;
			out_hit_q   <= 1'b0;
			out_idx_q   <= '0;
			out_dist_q  <= '0;
			mx_q        <= '0;
			p_q         <= '0;
			acc_q       <= '0;
			den_q       <= '0;
			t_q         <= '0;
			len_q       <= '0;
			k_q         <= '0;
			for (int i = 0; i < 3; i++) begin
				m_q[i]    <= '0;
				u_q[i]    <= '0;
				a_q[i]    <= '0;
				b_q[i]    <= '0;
				pm_q[i]   <= '0;
				v_q[0][i] <= '0;
				v_q[1][i] <= '0;
				x_q[0][i] <= '0;
				x_q[1][i] <= '0;
			end
		end else begin
			if (out_valid_q && pick.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_fire) begin
						for (int i = 0; i < 3; i++) begin
							v_q[0][i] <= sat32(33'(e_in[i]) - 33'(s_in[i]));
							v_q[1][i] <= sat32(33'(s_in[i]) - 33'(cfg_org_q[i]));
						end
						last_q <= edges.last_edge;
						state_q <= S_CHK;
						if (cnt_q == '0) begin
							// new pass: reload threshold, latch direction
							best_dist_q <= cfg_thr_q;
							best_idx_q  <= '0;
							found_q     <= 1'b0;
							for (int i = 0; i < 3; i++) begin
								m_q[i] <= dmag[i];
								u_q[i] <= '0;
							end
							mx_q <= dmax;
							if (dmax != '0) begin
								dphase_q <= 1'b1;
								state_q  <= S_DNORM;
							end
						end
					end
				end
				S_DNORM: begin
					if (mx_q[31:30] == 2'b00) begin
						mx_q <= mx_q << 1;
						for (int i = 0; i < 3; i++) begin
							m_q[i] <= m_q[i] << 1;
						end
					end else begin
						op_q    <= OP_DSQ;
						idx_q   <= '0;
						acc_q   <= '0;
						state_q <= S_MUL;
					end
				end
				S_CHK: begin
					if (cnt_q >= CNT_W'(MAX_EDGES) || u_zero) begin
						state_q <= S_FIN;
					end else begin
						op_q    <= OP_PDOT;
						side_q  <= 1'b0;
						idx_q   <= '0;
						acc_q   <= '0;
						state_q <= S_MUL;
					end
				end
				S_MUL: begin
					state_q <= S_MWB;
				end
				S_MWB: begin
					case (op_q)
						OP_PROJ: x_q[side_q][idx_q] <= proj_w;
						OP_TB:   pm_q[idx_q] <= cmag_w[30:0];
						default: acc_q <= sum_w;
					endcase
					if (idx_q != 2'd2) begin
						idx_q   <= idx_q + 2'd1;
						state_q <= S_MUL;
					end else begin
						idx_q <= '0;
						acc_q <= '0;
						case (op_q)
							OP_DSQ: state_q <= S_SQRT;
							OP_PDOT: begin
								p_q     <= P_W'(sum_w >>> FRAC_BITS);
								op_q    <= OP_PROJ;
								state_q <= S_MUL;
							end
							OP_PROJ: begin
								if (!side_q) begin
									side_q  <= 1'b1;
									op_q    <= OP_PDOT;
									state_q <= S_MUL;
								end else begin
									state_q <= S_KSH;
								end
							end
							OP_DEN: begin
								den_q   <= sum_w[DIV_W-1:0];
								op_q    <= OP_DAB;
								state_q <= S_MUL;
							end
							OP_DAB: begin
								if (den_q == '0) begin
									// parallel or degenerate edge
									state_q <= S_FIN;
								end else if (num_pos) begin
									state_q <= S_DIV;
								end else begin
									t_q     <= '0;
									op_q    <= OP_TB;
									state_q <= S_MUL;
								end
							end
							OP_TB: begin
								op_q    <= OP_PSQ;
								state_q <= S_MUL;
							end
							OP_PSQ:  state_q <= S_SQRT;
							default: state_q <= S_IDLE;
						endcase
					end
				end
				S_KSH: begin
					k_q <= k_w;
					for (int i = 0; i < 3; i++) begin
						a_q[i] <= AB_W'(x_q[1][i] >>> k_w);
						b_q[i] <= AB_W'(x_q[0][i] >>> k_w);
					end
					op_q    <= OP_DEN;
					idx_q   <= '0;
					acc_q   <= '0;
					state_q <= S_MUL;
				end
				S_SQRT: begin
					if (sq_stat.done) begin
						if (dphase_q) begin
							len_q   <= sq_root;
							idx_q   <= '0;
							state_q <= S_DIV;
						end else begin
							if (dist_w < best_dist_q) begin
								best_dist_q <= dist_w;
								best_idx_q  <= cnt_q[IDX_W-1:0];
								found_q     <= 1'b1;
							end
							state_q <= S_FIN;
						end
					end
				end
				S_DIV: begin
					if (div_stat.done) begin
						if (dphase_q) begin
							u_q[idx_q] <= cfg_dir_q[idx_q][31] ? -$signed({1'b0, div_quo})
								: $signed({1'b0, div_quo});
							if (idx_q == 2'd2) begin
								idx_q    <= '0;
								dphase_q <= 1'b0;
								state_q  <= S_CHK;
							end else begin
								idx_q <= idx_q + 2'd1;
							end
						end else begin
							t_q     <= div_quo;
							op_q    <= OP_TB;
							idx_q   <= '0;
							state_q <= S_MUL;
						end
					end
				end
				S_FIN: begin
					if (!last_q) begin
						if (cnt_q < CNT_W'(MAX_EDGES)) begin
							cnt_q <= cnt_q + CNT_W'(1);
						end
						state_q <= S_IDLE;
					end else if (!out_busy) begin
						out_valid_q <= 1'b1;
						out_hit_q   <= found_q;
						out_idx_q   <= best_idx_q;
						out_dist_q  <= found_q ? best_dist_q : '0;
						cnt_q       <= '0;
						found_q     <= 1'b0;
						best_idx_q  <= '0;
						best_dist_q <= cfg_thr_q;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign pick.valid          = out_valid_q;
	assign pick.hit            = out_hit_q;
	assign pick.hit_edge_index = out_idx_q;
	assign pick.hit_distance   = out_dist_q;

	`REP_ASSERT_NXT(a_busy_after_accept, clk, arst_n, in_fire, !in_ready)
	`REP_ASSERT_IMP(a_miss_is_zero, clk, arst_n, out_valid_q && !out_hit_q, out_idx_q == '0 && out_dist_q == '0)
	`REP_ASSERT_IMP(a_cnt_bound, clk, arst_n, 1'b1, cnt_q <= CNT_W'(MAX_EDGES))
endmodule
`default_nettype wire

// ===== rtl/rep_mul.sv =====
// Shared signed multiplier with a registered product.
// Depends on rep_pkg.
`timescale 1ns / 1ps
`default_nettype none
module rep_mul (
	input  wire logic                               clk,
	input  wire logic                               en,
	input  wire logic signed [rep_pkg::MUL_A_W-1:0] a,
	input  wire logic signed [rep_pkg::MUL_B_W-1:0] b,
	output logic signed [rep_pkg::MUL_P_W-1:0]      p
);
	import rep_pkg::*;
	logic signed [MUL_P_W-1:0] p_q;

	always_ff @(posedge clk) begin
		if (en) begin
			p_q <= MUL_P_W'(a) * MUL_P_W'(b);
		end
	end

	assign p = p_q;
endmodule
`default_nettype wire

// ===== rtl/rep_div.sv =====
// Fractional restoring divider: quo = floor(num * 2^30 / den), 1.0 when num >= den.
// One quotient bit per cycle. Depends on rep_pkg.
`timescale 1ns / 1ps
`default_nettype none
module rep_div (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           start,
	input  wire logic [rep_pkg::DIV_W-1:0]      num,
	input  wire logic [rep_pkg::DIV_W-1:0]      den,
	output logic [rep_pkg::Q_W-1:0]             quo,
	output rep_pkg::unit_stat_t                 stat
);
	import rep_pkg::*;
	logic [DIV_W-1:0] rem_q;
	logic [DIV_W-1:0] den_q;
	logic [Q_W-1:0]   quo_q;
	logic [4:0]       cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [DIV_W:0]   rem2;
	logic             fits;

	assign rem2 = {rem_q, 1'b0};
	assign fits = rem2 >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				if (num >= den) begin
					done_q <= 1'b1;
				end else begin
					busy_q <= 1'b1;
					cnt_q  <= 5'(FRAC_BITS);
				end
			end else if (busy_q) begin
				cnt_q <= cnt_q - 5'd1;
				if (cnt_q == 5'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			den_q <= den;
			rem_q <= num;
			quo_q <= (num >= den) ? ONE_Q30 : '0;
		end else if (busy_q) begin
			rem_q <= fits ? DIV_W'(rem2 - {1'b0, den_q}) : rem2[DIV_W-1:0];
			quo_q <= {quo_q[Q_W-2:0], fits};
		end
	end

	assign quo       = quo_q;
	assign stat.busy = busy_q;
	assign stat.done = done_q;
endmodule
`default_nettype wire

// ===== rtl/rep_sqrt.sv =====
// Integer square root of a 64-bit value, one result bit per cycle.
// Depends on rep_pkg.
`timescale 1ns / 1ps
`default_nettype none
module rep_sqrt (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      start,
	input  wire logic [rep_pkg::SQ_W-1:0]  x,
	output logic [rep_pkg::ROOT_W-1:0]     root,
	output rep_pkg::unit_stat_t            stat
);
	import rep_pkg::*;
	logic [SQ_W-1:0] x_q;
	logic [SQ_W-1:0] r_q;
	logic [4:0]      step_q;
	logic            busy_q;
	logic            done_q;
	logic [SQ_W-1:0] bit_w;
	logic [SQ_W:0]   rb;
	logic            take;

	assign bit_w = SQ_W'(1) << {step_q, 1'b0};
	assign rb    = {1'b0, r_q} + {1'b0, bit_w};
	assign take  = {1'b0, x_q} >= rb;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= 5'd31;
			end else if (busy_q) begin
				step_q <= step_q - 5'd1;
				if (step_q == 5'd0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			x_q <= x;
			r_q <= '0;
		end else if (busy_q) begin
			if (take) begin
				x_q <= x_q - rb[SQ_W-1:0];
				r_q <= (r_q >> 1) + bit_w;
			end else begin
				r_q <= r_q >> 1;
			end
		end
	end

	assign root      = r_q[ROOT_W-1:0];
	assign stat.busy = busy_q;
	assign stat.done = done_q;
endmodule
`default_nettype wire

// ===== sim/testbench.sv =====
// Self-checking testbench for ray_edge_pick_nearest_core: streams edges, predicts each pick.
// Depends on rep_pkg, rep_edge_if, rep_result_if and the core RTL.
`timescale 1ns / 1ps
module testbench;
	import rep_pkg::*;

	typedef struct {
		logic signed [31:0] sx, sy, sz, ex, ey, ez;
		logic               last;
	} seg_t;

	typedef struct {
		logic              hit;
		logic [IDX_W-1:0]  idx;
		logic [DIST_W-1:0] distance;
	} pick_t;

	localparam int QUIET_LIMIT = 20000;
	localparam longint Q30 = 64'sd1 << 30;

	logic        clk;
	logic        arst_n;
	logic        psel, penable, pwrite;
	logic [4:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	rep_edge_if   edges_ch();
	rep_result_if pick_ch();

	ray_edge_pick_nearest_core DUT (
		.clk(clk), .arst_n(arst_n), .edges(edges_ch.sink), .pick(pick_ch.source),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	// ---------------------------------------------------------------------
	// Predictor state: our own copy of the registers and the pass state.
	// ---------------------------------------------------------------------
	longint      org[3];
	longint      dir[3];
	int unsigned thresh;
	longint      unit_dir[3];
	int unsigned best_dist;
	int unsigned best_idx;
	int unsigned edge_cnt;
	bit          found;

	pick_t expected_picks[$];

	int  errors      = 0;
	int  edges_sent  = 0;
	int  picks_seen  = 0;
	int  hits_seen   = 0;
	bit  fast_mode   = 0;  // no idling on either side
	int  hold_req    = 0;  // receiver hold-off, in cycles
	int  quiet       = 0;

	initial begin
		clk = 0;
		forever #2 clk = ~clk;
	end

	function automatic longint clamp32(longint x);
		if (x > 64'sd2147483647) return 64'sd2147483647;
		if (x < -64'sd2147483648) return -64'sd2147483648;
		return x;
	endfunction

	function automatic longint unsigned abs64(longint x);
		return x < 0 ? longint'(-x) : longint'(x);
	endfunction

	function automatic longint unsigned int_sqrt(longint unsigned x);
		longint unsigned r = 0;
		longint unsigned b = 64'h4000_0000_0000_0000;
		while (b > x) b >>= 2;
		while (b != 0) begin
			if (x >= r + b) begin
				x -= r + b;
				r = (r >> 1) + b;
			end else
				r >>= 1;
			b >>= 2;
		end
		return r;
	endfunction

	// Normalize the direction registers to Q2.30; all zero means no direction.
	function automatic void latch_unit_dir();
		longint unsigned m[3];
		longint unsigned mx = 0, sum = 0, len, q;
		int sh = 0;
		for (int i = 0; i < 3; i++) begin
			m[i] = abs64(dir[i]);
			if (m[i] > mx) mx = m[i];
		end
		if (mx == 0) begin
			for (int i = 0; i < 3; i++) unit_dir[i] = 0;
			return;
		end
		while ((mx << sh) < (64'd1 << 30)) sh++;
		for (int i = 0; i < 3; i++) begin
			m[i] <<= sh;
			sum += m[i] * m[i];
		end
		len = int_sqrt(sum);
		for (int i = 0; i < 3; i++) begin
			q = (m[i] << 30) / len;
			unit_dir[i] = dir[i] < 0 ? -longint'(q) : longint'(q);
		end
	endfunction

	// Part of v perpendicular to the ray.
	function automatic void perp(input longint v[3], output longint o[3]);
		longint p = 0;
		for (int i = 0; i < 3; i++) p += v[i] * unit_dir[i];
		p = p >>> 30;
		for (int i = 0; i < 3; i++) o[i] = v[i] - ((p * unit_dir[i]) >>> 30);
	endfunction

	// Segment-to-line distance; returns 0 for a skipped edge.
	function automatic bit seg_line_dist(input longint s[3], input longint e[3],
			output int unsigned d);
		longint ed[3], wd[3], ep[3], wp[3], a[3], b[3];
		longint den = 0, dab = 0, num, t;
		longint unsigned mx = 0, sum = 0, r, rem, q, pm;
		int k = 0;
		d = 0;
		if (unit_dir[0] == 0 && unit_dir[1] == 0 && unit_dir[2] == 0) return 0;
		for (int i = 0; i < 3; i++) begin
			ed[i] = clamp32(e[i] - s[i]);
			wd[i] = clamp32(s[i] - org[i]);
		end
		perp(ed, ep);
		perp(wd, wp);
		for (int i = 0; i < 3; i++) begin
			if (abs64(ep[i]) > mx) mx = abs64(ep[i]);
			if (abs64(wp[i]) > mx) mx = abs64(wp[i]);
		end
		while ((mx >> k) >= (64'd1 << 29)) k++;
		for (int i = 0; i < 3; i++) begin
			a[i] = wp[i] >>> k;
			b[i] = ep[i] >>> k;
			den += b[i] * b[i];
			dab += a[i] * b[i];
		end
		if (den == 0) return 0;
		num = -dab;
		if (num <= 0) t = 0;
		else if (num >= den) t = Q30;
		else begin
			rem = num;
			q = 0;
			for (int i = 0; i < 30; i++) begin
				rem <<= 1;
				q <<= 1;
				if (rem >= longint'(den)) begin
					rem -= den;
					q |= 1;
				end
			end
			t = q;
		end
		for (int i = 0; i < 3; i++) begin
			pm = abs64(a[i] + ((t * b[i]) >>> 30));
			sum += pm * pm;
		end
		r = int_sqrt(sum) << k;
		d = r > 64'h7FFF_FFFF ? 32'h7FFF_FFFF : int'(r);
		return 1;
	endfunction

	// Advance the pass state by one accepted edge; queue a pick on the last one.
	function automatic void predict_pick(seg_t it);
		longint s[3], e[3];
		int unsigned d;
		pick_t p;
		if (edge_cnt == 0) begin
			latch_unit_dir();
			best_dist = thresh;
			best_idx  = 0;
			found     = 0;
		end
		s[0] = it.sx; s[1] = it.sy; s[2] = it.sz;
		e[0] = it.ex; e[1] = it.ey; e[2] = it.ez;
		if (edge_cnt < MAX_EDGES) begin
			if (seg_line_dist(s, e, d) && d < best_dist) begin
				best_dist = d;
				best_idx  = edge_cnt;
				found     = 1;
			end
			edge_cnt++;
		end
		if (!it.last) return;
		p.hit      = found;
		p.idx      = found ? best_idx[IDX_W-1:0] : '0;
		p.distance = found ? best_dist[DIST_W-1:0] : '0;
		expected_picks.push_back(p);
		edge_cnt  = 0;
		found     = 0;
		best_idx  = 0;
		best_dist = thresh;
	endfunction

	// ---------------------------------------------------------------------
	// Config port: setup + access write, then a read back of the register.
	// ---------------------------------------------------------------------
	task automatic write_reg(reg_idx_t r, logic [31:0] val);
		logic [31:0] want;
		@(posedge clk);
		psel <= 1; penable <= 0; pwrite <= 1; paddr <= 5'(r * 4); pwdata <= val;
		@(posedge clk);
		penable <= 1;
		@(posedge clk);
		psel <= 1; penable <= 0; pwrite <= 0;
		@(posedge clk);
		penable <= 1;
		@(posedge clk);
		psel <= 0; penable <= 0;
		want = (r == REG_THR) ? {1'b0, val[30:0]} : val;
		if ((r == REG_THR ? {1'b0, prdata[30:0]} : prdata) !== want) begin
			$error("readback reg %0d: expected %h, actual %h", r, want, prdata);
			errors++;
		end
		if (r <= REG_ORG_Z) org[r] = longint'($signed(val));
		else if (r <= REG_DIR_Z) dir[r - REG_DIR_X] = longint'($signed(val));
		else thresh = val[30:0];
	endtask

	task automatic set_ray(longint ox, longint oy, longint oz,
			longint dx, longint dy, longint dz, int unsigned thr);
		write_reg(REG_ORG_X, ox[31:0]);
		write_reg(REG_ORG_Y, oy[31:0]);
		write_reg(REG_ORG_Z, oz[31:0]);
		write_reg(REG_DIR_X, dx[31:0]);
		write_reg(REG_DIR_Y, dy[31:0]);
		write_reg(REG_DIR_Z, dz[31:0]);
		write_reg(REG_THR, thr);
	endtask

	// Wait for every pick, then let the core finish before config writes.
	task automatic settle();
		while (expected_picks.size() != 0) @(posedge clk);
		repeat (400) @(posedge clk);
	endtask

	// ---------------------------------------------------------------------
	// Edge sender: valid stays high across back-to-back transfers.
	// ---------------------------------------------------------------------
	task automatic send_edge(seg_t it);
		int gap;
		gap = fast_mode ? 0 : $urandom_range(0, 7);
		if (gap > 0) begin
			edges_ch.valid <= 0;
			repeat (gap) @(posedge clk);
		end
		edges_ch.valid     <= 1;
		edges_ch.start_x   <= it.sx;
		edges_ch.start_y   <= it.sy;
		edges_ch.start_z   <= it.sz;
		edges_ch.end_x     <= it.ex;
		edges_ch.end_y     <= it.ey;
		edges_ch.end_z     <= it.ez;
		edges_ch.last_edge <= it.last;
		do @(posedge clk); while (!edges_ch.ready);
		predict_pick(it);
		edges_sent++;
	endtask

	task automatic end_burst();
		@(posedge clk);
		edges_ch.valid <= 0;
	endtask

	function automatic seg_t mk(longint sx, longint sy, longint sz,
			longint ex, longint ey, longint ez, bit last);
		seg_t it;
		it.sx = clamp32(sx); it.sy = clamp32(sy); it.sz = clamp32(sz);
		it.ex = clamp32(ex); it.ey = clamp32(ey); it.ez = clamp32(ez);
		it.last = last;
		return it;
	endfunction

	function automatic seg_t rand_seg(bit last);
		seg_t it;
		it.sx = $urandom; it.sy = $urandom; it.sz = $urandom;
		it.ex = $urandom; it.ey = $urandom; it.ez = $urandom;
		it.last = last;
		return it;
	endfunction

	// Edge passing near a random point on the current ray.
	function automatic seg_t near_seg(bit last, int spread);
		longint lam, p[3], a[3], b[3];
		lam = longint'($signed($urandom_range(0, 1 << 19))) - (1 << 18);
		for (int i = 0; i < 3; i++) begin
			p[i] = org[i] + ((dir[i] * lam) >>> 16);
			a[i] = p[i] + $urandom_range(0, 2 * spread) - spread;
			b[i] = p[i] - $urandom_range(0, 2 * spread) + spread;
		end
		return mk(a[0], a[1], a[2], b[0], b[1], b[2], last);
	endfunction

	// ---------------------------------------------------------------------
	// Pick receiver and checker.
	// ---------------------------------------------------------------------
	initial begin
		int gap;
		pick_t exp_p;
		pick_ch.ready <= 0;
		@(posedge arst_n);
		forever begin
			if (hold_req > 0) begin
				pick_ch.ready <= 0;
				repeat (hold_req) @(posedge clk);
				hold_req = 0;
			end
			gap = fast_mode ? 0 : $urandom_range(0, 7);
			if (gap > 0) begin
				pick_ch.ready <= 0;
				repeat (gap) @(posedge clk);
			end
			pick_ch.ready <= 1;
			do @(posedge clk); while (!pick_ch.valid);
			picks_seen++;
			if (pick_ch.hit) hits_seen++;
			if (expected_picks.size() == 0) begin
				$error("pick transfer with no pick expected");
				errors++;
			end else begin
				exp_p = expected_picks.pop_front();
				if (pick_ch.hit !== exp_p.hit) begin
					$error("hit: expected %0d, actual %0d", exp_p.hit, pick_ch.hit);
					errors++;
				end
				if (pick_ch.hit_edge_index !== exp_p.idx) begin
					$error("hit_edge_index: expected %0d, actual %0d",
						exp_p.idx, pick_ch.hit_edge_index);
					errors++;
				end
				if (pick_ch.hit_distance !== exp_p.distance) begin
					$error("hit_distance: expected %0d, actual %0d",
						exp_p.distance, pick_ch.hit_distance);
					errors++;
				end
			end
		end
	end

	// Watchdog: any transfer or config access counts as progress.
	always @(posedge clk) begin
		if ((edges_ch.valid && edges_ch.ready) || (pick_ch.valid && pick_ch.ready) || psel
				|| !arst_n)
			quiet <= 0;
		else
			quiet <= quiet + 1;
		if (quiet >= QUIET_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	// ---------------------------------------------------------------------
	// Tests
	// ---------------------------------------------------------------------

	// Reset values: ray down -z through the origin, threshold about 0.1.
	task automatic test_reset_ray();
		longint one = 65536;
		send_edge(mk(-one, 2 * one, 0, one, 2 * one, 0, 0));    // 2.0 away, no hit
		send_edge(mk(-one, 3277, 5, one, 3277, 9, 0));          // about 0.05, hit
		send_edge(mk(100, 100, 7, 100, 100, 7, 0));             // degenerate
		send_edge(mk(50, 0, -one, 50, 0, one, 0));              // parallel to ray
		send_edge(mk(one / 4, -one, 0, one / 4, one, 0, 1));    // 0.25, no hit
		// pass with no hit at all
		send_edge(mk(one, one, 0, 2 * one, one, 0, 1));
		end_burst();
	endtask

	// Identical distances: the earlier edge wins.
	task automatic test_ties();
		send_edge(mk(-65536, 1000, 0, 65536, 1000, 0, 0));
		send_edge(mk(-65536, 1000, 3, 65536, 1000, 3, 0));
		send_edge(mk(-65536, -1000, 0, 65536, -1000, 0, 1));
		end_burst();
	endtask

	// Coordinate extremes and saturating differences.
	task automatic test_coord_extremes();
		longint lo = -64'sd2147483648, hi = 64'sd2147483647;
		send_edge(mk(lo, lo, lo, hi, hi, hi, 0));
		send_edge(mk(hi, hi, hi, lo, lo, lo, 0));
		send_edge(mk(lo, hi, 0, hi, lo, 0, 0));
		send_edge(mk(hi, 0, lo, lo, 0, hi, 0));
		send_edge(mk(0, 0, 0, 0, 0, 0, 1));
		end_burst();
		settle();
		set_ray(-64'sd2147483648, 64'sd2147483647, 0, 1, -1, 0, 32'h7FFF_FFFF);
		send_edge(mk(hi, lo, 0, lo, hi, 5, 0));
		send_edge(mk(0, 0, 0, 1, 1, 1, 1));
		end_burst();
		settle();
		set_ray(0, 0, 0, -64'sd2147483648, 64'sd2147483647, -64'sd2147483648, 0);
		send_edge(mk(-65536, 0, 0, 65536, 0, 0, 1));   // threshold zero: never a hit
		end_burst();
	endtask

	// Zero direction skips every edge of the pass.
	task automatic test_zero_dir();
		settle();
		set_ray(0, 0, 0, 0, 0, 0, 32'h7FFF_FFFF);
		send_edge(mk(-65536, 10, 0, 65536, 10, 0, 0));
		send_edge(mk(5, -65536, 0, 5, 65536, 0, 1));
		end_burst();
	endtask

	// Random phases of config, each with several passes of mostly near edges.
	task automatic test_random_passes(int n_edges);
		int sent = 0, len, spread;
		longint o[3], d[3];
		int unsigned thr;
		while (sent < n_edges) begin
			settle();
			fast_mode = ($urandom_range(0, 3) == 0);
			for (int i = 0; i < 3; i++) begin
				o[i] = longint'($signed($urandom_range(0, 1 << 22))) - (1 << 21);
				d[i] = longint'($signed($urandom_range(0, 1 << 18))) - (1 << 17);
				if ($urandom_range(0, 7) == 0) d[i] = longint'($signed($urandom));
				if ($urandom_range(0, 9) == 0) d[i] = 0;
			end
			thr = $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 1 << 17);
			set_ray(o[0], o[1], o[2], d[0], d[1], d[2], thr);
			for (int p = 0; p < 4; p++) begin
				len = $urandom_range(1, 8);
				spread = 1 << $urandom_range(8, 18);
				for (int j = 0; j < len; j++) begin
					if ($urandom_range(0, 6) == 0)
						send_edge(rand_seg(j == len - 1));
					else
						send_edge(near_seg(j == len - 1, spread));
					sent++;
				end
			end
			end_burst();
		end
		fast_mode = 0;
	endtask

	// Receiver stalls for a long stretch; edges keep coming until input backs up.
	task automatic test_backpressure();
		settle();
		set_ray(0, 0, 0, 0, 0, -65536, 6554);
		fast_mode = 1;
		hold_req  = 3000;
		for (int j = 0; j < 8; j++)
			send_edge(mk(-65536, 100 * j, 0, 65536, 100 * j, 0, 1));
		end_burst();
		fast_mode = 0;
	endtask

	initial begin
		arst_n  <= 0;
		psel    <= 0;
		penable <= 0;
		pwrite  <= 0;
		paddr   <= '0;
		pwdata  <= '0;
		edges_ch.valid     <= 0;
		edges_ch.start_x   <= '0;
		edges_ch.start_y   <= '0;
		edges_ch.start_z   <= '0;
		edges_ch.end_x     <= '0;
		edges_ch.end_y     <= '0;
		edges_ch.end_z     <= '0;
		edges_ch.last_edge <= 0;
		org[0] = 0; org[1] = 0; org[2] = 0;
		dir[0] = 0; dir[1] = 0; dir[2] = -65536;
		thresh    = 6554;
		best_dist = 6554;
		best_idx  = 0;
		edge_cnt  = 0;
		found     = 0;
		repeat (7) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		test_reset_ray();
		test_ties();
		test_coord_extremes();
		test_zero_dir();
		test_backpressure();
		test_random_passes(380);

		while (expected_picks.size() != 0) @(posedge clk);
		repeat (400) @(posedge clk);
		$display("Run covered %0d edges and %0d picks (%0d hits), over directed, random and",
			edges_sent, picks_seen, hits_seen);
		$display("backpressure passes with %0d check errors.", errors);
		if (errors == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end
endmodule
